@@ src/mbw_pkg.sv @@
// ----------------------------------------------------------------------------
// mbw_pkg
// Shared types and constants of the maze backtracker walk block.
// ----------------------------------------------------------------------------
package mbw_pkg;

  localparam int POS_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int DIR_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

  localparam logic [CFG_W-1:0] GRID_RESET = 7'd16;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DRAW  = 1'b1;

  localparam logic WALL_TOP  = 1'b0;
  localparam logic WALL_LEFT = 1'b1;

  localparam logic [3:0] TRIED_ALL = 4'hF;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef struct packed {
    logic clr_we;
    logic load;
    logic commit;
    logic start;
  } mbw_cmd_t;

  typedef struct packed {
    logic clr_last;
  } mbw_status_t;

endpackage

@@ src/mbw_in_if.sv @@
// ----------------------------------------------------------------------------
// mbw_in_if
// Input channel: one start or direction-draw word per handshake.
// ----------------------------------------------------------------------------
interface mbw_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [mbw_pkg::DIR_W-1:0]  direction;

  modport source (output valid, output action, output direction, input ready);
  modport sink   (input valid, input action, input direction, output ready);
endinterface

@@ src/mbw_out_if.sv @@
// ----------------------------------------------------------------------------
// mbw_out_if
// Output channel: one step result word per handshake.
// ----------------------------------------------------------------------------
interface mbw_out_if;
  logic                       valid;
  logic                       ready;
  logic                       carved;
  logic [mbw_pkg::POS_W-1:0]  wall_row;
  logic [mbw_pkg::POS_W-1:0]  wall_col;
  logic                       wall_kind;
  logic [mbw_pkg::POS_W-1:0]  cur_row;
  logic [mbw_pkg::POS_W-1:0]  cur_col;
  logic                       backtracked;
  logic                       done_res;

  modport source (output valid, output carved, output wall_row, output wall_col,
                  output wall_kind, output cur_row, output cur_col,
                  output backtracked, output done_res, input ready);
  modport sink   (input valid, input carved, input wall_row, input wall_col,
                  input wall_kind, input cur_row, input cur_col,
                  input backtracked, input done_res, output ready);
endinterface

@@ src/maze_backtracker_walk.sv @@
// ----------------------------------------------------------------------------
// maze_backtracker_walk
// Randomized depth-first maze carver, one direction draw per input word.
// ----------------------------------------------------------------------------
// A draw word is handled in order: the accept cycle reads the visited map and
// the stack top from their synchronous memories; then ST_EVAL, once no earlier
// result waits or it is being taken, evaluates the step, writes the visited map
// and, with room, the stack on a carve and loads the result register. A new word
// is taken while the previous result waits on the output. A start word, and
// reset itself, sweep the visited map one cell per cycle, during which no input
// word is taken; configuration writes are taken at any time.
module maze_backtracker_walk #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mbw_pkg::CFG_W-1:0]     cfg_data_i,
  mbw_in_if.sink                        in_i,
  mbw_out_if.source                     out_o
);
  import mbw_pkg::*;

  mbw_cmd_t    cmd;
  mbw_status_t status;

  mbw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mbw_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_direction_i (in_i.direction),
    .cmd_i          (cmd),
    .status_o       (status),
    .carved_o       (out_o.carved),
    .wall_row_o     (out_o.wall_row),
    .wall_col_o     (out_o.wall_col),
    .wall_kind_o    (out_o.wall_kind),
    .cur_row_o      (out_o.cur_row),
    .cur_col_o      (out_o.cur_col),
    .backtracked_o  (out_o.backtracked),
    .done_res_o     (out_o.done_res)
  );

endmodule

@@ src/mbw_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbw_ctrl
// Controller: sequences clear sweeps, memory reads and step commits.
// ----------------------------------------------------------------------------
module mbw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_action_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  mbw_pkg::mbw_status_t status_i,
  output mbw_pkg::mbw_cmd_t    cmd_o
);
  import mbw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLEAR = 3'b010,
    ST_EVAL  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   start_q, start_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    start_d      = start_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.start  = start_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == ACT_START) begin
            start_d = 1'b1;
            state_d = ST_CLEAR;
          end else begin
            start_d     = 1'b0;
            cmd_o.load  = 1'b1;
            state_d     = ST_EVAL;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (status_i.clr_last) begin
          state_d = start_q ? ST_EVAL : ST_IDLE;
        end
      end
      ST_EVAL: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  ast_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken on the cycle after an accept");

  ast_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over an untaken word");

  ast_draw_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_action_i == ACT_DRAW) |=> (state_q == ST_EVAL))
    else $error("draw not followed by evaluation");

endmodule

@@ src/mbw_dpath.sv @@
// ----------------------------------------------------------------------------
// mbw_dpath
// Datapath: grid registers, visited map, path stack, walker state, result.
// ----------------------------------------------------------------------------
module mbw_dpath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mbw_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [mbw_pkg::DIR_W-1:0]     in_direction_i,
  input  mbw_pkg::mbw_cmd_t             cmd_i,
  output mbw_pkg::mbw_status_t          status_o,
  output logic                          carved_o,
  output logic [mbw_pkg::POS_W-1:0]     wall_row_o,
  output logic [mbw_pkg::POS_W-1:0]     wall_col_o,
  output logic                          wall_kind_o,
  output logic [mbw_pkg::POS_W-1:0]     cur_row_o,
  output logic [mbw_pkg::POS_W-1:0]     cur_col_o,
  output logic                          backtracked_o,
  output logic                          done_res_o
);
  import mbw_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = $clog2(CELLS);
  localparam int CMPA  = (RW > CW) ? RW + 1 : CW + 1;
  localparam int CMPW  = (CMPA > CFG_W) ? CMPA : CFG_W;

  logic [CFG_W-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= GRID_RESET;
      cols_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_ROWS: rows_q <= cfg_data_i;
        REG_GRID_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [RW-1:0] pos_row_q;
  logic [CW-1:0] pos_col_q;
  logic [3:0]    tried_q;
  logic          fin_q;
  logic [AW:0]   count_q;
  logic [AW-1:0] clr_cnt_q;

  // neighbor in the incoming direction
  dir_e          dir_in;
  logic [RW:0]   nr_w;
  logic [CW:0]   nc_w;
  logic          no_wrap;
  logic          in_grid;
  logic [AW-1:0] nbr_addr;

  always_comb begin
    dir_in  = dir_e'(in_direction_i);
    nr_w    = {1'b0, pos_row_q};
    nc_w    = {1'b0, pos_col_q};
    no_wrap = 1'b1;
    case (dir_in)
      DIR_UP: begin
        no_wrap = (pos_row_q != '0);
        nr_w    = nr_w - 1'b1;
      end
      DIR_DOWN:  nr_w = nr_w + 1'b1;
      DIR_LEFT: begin
        no_wrap = (pos_col_q != '0);
        nc_w    = nc_w - 1'b1;
      end
      default:   nc_w = nc_w + 1'b1;
    endcase
    in_grid = no_wrap
           && (CMPW'(nr_w) < CMPW'(rows_q)) && (CMPW'(nr_w) < CMPW'(MAX_ROWS))
           && (CMPW'(nc_w) < CMPW'(cols_q)) && (CMPW'(nc_w) < CMPW'(MAX_COLS));
    nbr_addr = in_grid ? AW'(AW'(nr_w[RW-1:0]) * AW'(MAX_COLS)) + AW'(nc_w[CW-1:0])
                       : '0;
  end

  dir_e          dir_q;
  logic [RW-1:0] nr_q;
  logic [CW-1:0] nc_q;
  logic          inside_q;
  logic [AW-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dir_q    <= dir_in;
      nr_q     <= nr_w[RW-1:0];
      nc_q     <= nc_w[CW-1:0];
      inside_q <= in_grid;
      addr_q   <= nbr_addr;
    end
  end

  // visited map
  logic          vis_mem [CELLS];
  logic          vis_rd_q;
  logic          vis_we;
  logic [AW-1:0] vis_waddr;
  logic          vis_wdata;

  // path stack
  logic [RW+CW-1:0] stk_mem [CELLS];
  logic [RW+CW-1:0] stk_rd_q;
  logic [AW:0]      count_m1;
  logic             stk_we;

  // step evaluation
  logic          blocked, carve, pop_all, room;
  logic [3:0]    tried_new;
  logic          wk;
  logic [RW-1:0] wr;
  logic [CW-1:0] wc;

  always_comb begin
    blocked   = fin_q || tried_q[dir_q];
    carve     = !blocked && inside_q && !vis_rd_q;
    tried_new = tried_q | (4'b0001 << dir_q);
    pop_all   = !blocked && !carve && (tried_new == TRIED_ALL);
    room      = (count_q < (AW+1)'(CELLS));
    case (dir_q)
      DIR_UP: begin
        wr = pos_row_q; wc = pos_col_q; wk = WALL_TOP;
      end
      DIR_DOWN: begin
        wr = nr_q; wc = nc_q; wk = WALL_TOP;
      end
      DIR_LEFT: begin
        wr = pos_row_q; wc = pos_col_q; wk = WALL_LEFT;
      end
      default: begin
        wr = nr_q; wc = nc_q; wk = WALL_LEFT;
      end
    endcase
    vis_we    = cmd_i.clr_we || (cmd_i.commit && !cmd_i.start && carve);
    vis_waddr = cmd_i.clr_we ? clr_cnt_q : addr_q;
    vis_wdata = cmd_i.clr_we ? (cmd_i.start && clr_cnt_q == '0) : 1'b1;
    stk_we    = cmd_i.commit && !cmd_i.start && carve && room;
    count_m1  = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (cmd_i.load) begin
      vis_rd_q <= vis_mem[nbr_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[count_q[AW-1:0]] <= {nr_q, nc_q};
    end
    if (cmd_i.load) begin
      stk_rd_q <= stk_mem[count_m1[AW-1:0]];
    end
  end

  assign status_o.clr_last = (clr_cnt_q == AW'(CELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_cnt_q <= status_o.clr_last ? '0 : clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_row_q <= '0;
      pos_col_q <= '0;
      tried_q   <= '0;
      fin_q     <= 1'b0;
      count_q   <= '0;
    end else if (cmd_i.commit) begin
      if (cmd_i.start) begin
        pos_row_q <= '0;
        pos_col_q <= '0;
        tried_q   <= '0;
        fin_q     <= 1'b0;
        count_q   <= '0;
      end else if (carve) begin
        pos_row_q <= nr_q;
        pos_col_q <= nc_q;
        tried_q   <= '0;
        if (room) begin
          count_q <= count_q + 1'b1;
        end
      end else if (pop_all) begin
        if (count_q == '0) begin
          fin_q   <= 1'b1;
          tried_q <= tried_new;
        end else begin
          tried_q   <= '0;
          count_q   <= count_m1;
          pos_row_q <= stk_rd_q[RW+CW-1:CW];
          pos_col_q <= stk_rd_q[CW-1:0];
        end
      end else if (!blocked) begin
        tried_q <= tried_new;
      end
    end
  end

  // result word
  logic          carved_q, wall_kind_q, backtracked_q;
  logic [RW-1:0] wall_row_q;
  logic [CW-1:0] wall_col_q;
  logic          is_start_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      is_start_q    <= cmd_i.start;
      carved_q      <= !cmd_i.start && carve;
      wall_row_q    <= (!cmd_i.start && carve) ? wr : '0;
      wall_col_q    <= (!cmd_i.start && carve) ? wc : '0;
      wall_kind_q   <= (!cmd_i.start && carve) ? wk : WALL_TOP;
      backtracked_q <= !cmd_i.start && pop_all && (count_q != '0);
    end
  end

  assign carved_o      = carved_q;
  assign wall_row_o    = POS_W'(wall_row_q);
  assign wall_col_o    = POS_W'(wall_col_q);
  assign wall_kind_o   = wall_kind_q;
  assign cur_row_o     = POS_W'(pos_row_q);
  assign cur_col_o     = POS_W'(pos_col_q);
  assign backtracked_o = backtracked_q;
  assign done_res_o    = fin_q && !is_start_q;

  ast_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (AW+1)'(CELLS))
    else $error("stack count past depth");

  ast_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !cmd_i.start && carve && room) |=>
      (count_q == $past(count_q) + 1'b1))
    else $error("carve did not push");

  ast_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fin_q) |-> (count_q == '0))
    else $error("done with a non-empty stack");

endmodule
